FILE: design/sisl_pkg.sv
// Shared types, widths, register indexes and helper functions for the speed
// inertia slew limiter. No dependencies; every other design file uses it.

package sisl_pkg;

  localparam int SPD_W      = 16;  // speed fields at the ports
  localparam int X100_W     = 23;  // speed scaled by 100
  localparam int DIST_W     = 24;  // distance between two scaled speeds
  localparam int QUO_W      = 17;  // scaled speed divided by 100
  localparam int RATE_W     = 14;  // accel_rate, decel_rate
  localparam int TICK_W     = 17;  // tick_period
  localparam int PROD_W     = RATE_W + TICK_W;
  localparam int STEP_W     = 18;  // rate * tick / 10000
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK  = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = '0;
  localparam logic [TICK_W-1:0] TICK_RESET = 17'd100;

  // Exact floor(p / 10000) for p < 2**31 as (p * STEP_RECIP) >> STEP_SHIFT
  localparam int             RECIP_W    = 32;
  localparam logic [RECIP_W-1:0] STEP_RECIP = 32'd3518437209;
  localparam int             STEP_SHIFT = 45;

  // Exact floor(a / 100) for a <= 2**22 as (a * DIV100_RECIP) >> DIV100_SHIFT
  localparam logic [X100_W-1:0] DIV100_RECIP = 23'd5368710;
  localparam int                DIV100_SHIFT = 29;

  localparam logic signed [X100_W-1:0] SPEED_SCALE = 23'sd100;
  localparam logic signed [X100_W-1:0] WIN_SPAN    = 23'sd99;

  typedef struct packed {
    logic                    kind;          // 1: clear the speed
    logic signed [SPD_W-1:0] target_speed;
  } in_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] speed;
    logic                    changed;
  } out_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                     kind;
    logic signed [X100_W-1:0] tgt100;   // target * 100
    logic signed [X100_W-1:0] win_lo;   // scaled speeds that truncate to target
    logic signed [X100_W-1:0] win_hi;
  } cmd_t;

  // Per-tick step sizes derived from the configuration registers
  typedef struct packed {
    logic [STEP_W-1:0] acc;
    logic [STEP_W-1:0] dec;
  } steps_t;

  // Divide a scaled speed by 100, truncating toward zero
  function automatic logic signed [QUO_W-1:0] div100(input logic signed [X100_W-1:0] v);
    logic [X100_W-1:0]   mag;
    logic [2*X100_W-1:0] prod;
    logic [QUO_W-1:0]    quo;
    mag  = v[X100_W-1] ? X100_W'(-v) : X100_W'(v);
    prod = (2*X100_W)'(mag) * (2*X100_W)'(DIV100_RECIP);
    quo  = prod[DIV100_SHIFT +: QUO_W];
    return v[X100_W-1] ? $signed(QUO_W'(-quo)) : $signed(quo);
  endfunction

endpackage

FILE: design/speed_inertia_slew_limiter.sv
// Top level of the speed inertia slew limiter: configuration registers and
// the front end, queue, step unit and back end. Depends on sisl_pkg and all sisl_* modules.
//
//  channel   ports                          transfer when
//  ------    -----------------------------  -----------------------------
//  input     push, full, item               push && !full at rising clk
//  result    empty, pop, result             pop && !empty at rising clk
//  config    cfg_wen, cfg_index, cfg_wdata  cfg_wen at rising clk
//
// One item per cycle while the result side keeps up; a result passes through the
// front register, queue, update and result queue before it shows on the result ports.
// New rates take effect once the step unit's product and step registers update, in
// time for any item pushed after the write. Synchronous reset clears the speed and
// queues and loads the registers' reset values. A stalled result side fills the
// four-entry result queue, then the two-entry queue and front register, then raises full.

module speed_inertia_slew_limiter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  sisl_pkg::in_t                       item,
  output logic                                empty,
  input  logic                                pop,
  output sisl_pkg::out_t                      result,
  input  logic                                cfg_wen,
  input  logic [sisl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sisl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [sisl_pkg::RATE_W-1:0] accel_rate;
  logic [sisl_pkg::RATE_W-1:0] decel_rate;
  logic [sisl_pkg::TICK_W-1:0] tick_period;

  logic              q_space;
  logic              f_valid;
  sisl_pkg::cmd_t    f_cmd;
  logic              q_avail;
  sisl_pkg::cmd_t    q_head;
  logic              q_take;
  sisl_pkg::steps_t  steps;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_rate  <= sisl_pkg::RATE_RESET;
      decel_rate  <= sisl_pkg::RATE_RESET;
      tick_period <= sisl_pkg::TICK_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        sisl_pkg::REG_ACCEL: accel_rate  <= cfg_wdata[sisl_pkg::RATE_W-1:0];
        sisl_pkg::REG_DECEL: decel_rate  <= cfg_wdata[sisl_pkg::RATE_W-1:0];
        sisl_pkg::REG_TICK:  tick_period <= cfg_wdata[sisl_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Derive per-tick step sizes from the rates
  sisl_step u_step (
    .clk         (clk),
    .accel_rate  (accel_rate),
    .decel_rate  (decel_rate),
    .tick_period (tick_period),
    .steps       (steps)
  );

  // Accept and classify items
  sisl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .q_space   (q_space),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  // Decouple the front end from the back end
  sisl_midq u_midq (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_valid && q_space),
    .wr_cmd (f_cmd),
    .space  (q_space),
    .rd     (q_take),
    .avail  (q_avail),
    .head   (q_head)
  );

  // Advance the speed and queue results
  sisl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (q_avail),
    .cmd       (q_head),
    .cmd_take  (q_take),
    .steps     (steps),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: design/sisl_step.sv
// Step-size unit: turns the rate and tick period registers into per-tick steps.
// Depends on sisl_pkg. Two register stages: product, then reciprocal divide.

module sisl_step (
  input  logic                           clk,
  input  logic [sisl_pkg::RATE_W-1:0]    accel_rate,
  input  logic [sisl_pkg::RATE_W-1:0]    decel_rate,
  input  logic [sisl_pkg::TICK_W-1:0]    tick_period,
  output sisl_pkg::steps_t               steps
);

  localparam int QW = sisl_pkg::PROD_W + sisl_pkg::RECIP_W;

  logic [sisl_pkg::PROD_W-1:0] prod_acc;
  logic [sisl_pkg::PROD_W-1:0] prod_dec;
  logic [QW-1:0]               quo_acc;
  logic [QW-1:0]               quo_dec;

  always_comb begin
    quo_acc = QW'(prod_acc) * QW'(sisl_pkg::STEP_RECIP);
    quo_dec = QW'(prod_dec) * QW'(sisl_pkg::STEP_RECIP);
  end

  always_ff @(posedge clk) begin
    prod_acc  <= sisl_pkg::PROD_W'(accel_rate) * sisl_pkg::PROD_W'(tick_period);
    prod_dec  <= sisl_pkg::PROD_W'(decel_rate) * sisl_pkg::PROD_W'(tick_period);
    steps.acc <= quo_acc[sisl_pkg::STEP_SHIFT +: sisl_pkg::STEP_W];
    steps.dec <= quo_dec[sisl_pkg::STEP_SHIFT +: sisl_pkg::STEP_W];
  end

endmodule

FILE: design/sisl_front.sv
// Front end: accepts input items, scales the target and builds its window.
// Depends on sisl_pkg. Holds one classified item until the queue takes it.

module sisl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sisl_pkg::in_t      item,
  input  logic               q_space,
  output logic               cmd_valid,
  output sisl_pkg::cmd_t     cmd
);

  logic                                   accept;
  logic                                   advance;
  logic                                   cmd_valid_next;
  logic signed [sisl_pkg::X100_W-1:0]     tgt100;
  sisl_pkg::cmd_t                         cmd_next;

  assign advance = cmd_valid && q_space;
  assign full    = cmd_valid && !q_space;
  assign accept  = push && !full;

  always_comb begin
    tgt100 = sisl_pkg::X100_W'(item.target_speed) * sisl_pkg::SPEED_SCALE;
    cmd_next.kind   = item.kind;
    cmd_next.tgt100 = tgt100;
    // Scaled speeds that truncate toward zero onto the target
    cmd_next.win_lo = (item.target_speed > 0) ? tgt100 : tgt100 - sisl_pkg::WIN_SPAN;
    cmd_next.win_hi = (item.target_speed < 0) ? tgt100 : tgt100 + sisl_pkg::WIN_SPAN;
    cmd_valid_next  = accept || (cmd_valid && !advance);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_valid_next;
    end
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: design/sisl_midq.sv
// Two-entry queue between the front end and the back end.
// Depends on sisl_pkg for the classified item type.

module sisl_midq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  sisl_pkg::cmd_t wr_cmd,
  output logic           space,
  input  logic           rd,
  output logic           avail,
  output sisl_pkg::cmd_t head
);

  localparam logic [1:0] DEPTH = 2'd2;

  sisl_pkg::cmd_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;

  assign space = count < DEPTH;
  assign avail = count != 2'd0;
  assign head  = mem[rd_ptr];

  always_comb begin
    count_next = count + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && count == DEPTH))
    else $error("midq: write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && count == 2'd0))
    else $error("midq: read from empty queue");
`endif

endmodule

FILE: design/sisl_back.sv
// Back end: moves the scaled speed toward the target, divides by 100 and
// queues results. Depends on sisl_pkg.

module sisl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_avail,
  input  sisl_pkg::cmd_t     cmd,
  output logic               cmd_take,
  input  sisl_pkg::steps_t   steps,
  output logic               empty,
  input  logic               pop,
  output sisl_pkg::out_t     result
);

  localparam int          X  = sisl_pkg::X100_W;
  localparam int          D  = sisl_pkg::DIST_W;
  localparam int          S  = sisl_pkg::STEP_W;
  localparam logic [2:0]  RES_DEPTH = 3'd4;
  localparam logic signed [X-1:0] MAX_X100 = 23'sd3276800;

  logic signed [X-1:0] cur_x100;
  logic signed [X-1:0] cur_next;
  logic                exe_valid;
  logic signed [X-1:0] exe_old;
  logic signed [X-1:0] exe_new;

  logic                c_pos, c_neg, t_pos, t_neg;
  logic [X-1:0]        abs_c, abs_t;
  logic                opposite, grow, up, hit;
  logic [D-1:0]        gap;
  logic [S-1:0]        step, mag;
  logic signed [X-1:0] moved;

  logic signed [sisl_pkg::QUO_W-1:0] old_q;
  logic signed [sisl_pkg::QUO_W-1:0] new_q;
  sisl_pkg::out_t                    res_next;

  sisl_pkg::out_t mem [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     count;
  logic           deq;

  // Take a new item only if its result is sure to find a slot
  assign cmd_take = cmd_avail &&
                    (({1'b0, count} + {3'b0, exe_valid}) < {1'b0, RES_DEPTH});
  assign empty    = count == 3'd0;
  assign deq      = pop && !empty;
  assign result   = mem[rd_ptr];

  always_comb begin
    c_neg = cur_x100 < 0;
    c_pos = cur_x100 > 0;
    t_neg = cmd.tgt100 < 0;
    t_pos = cmd.tgt100 > 0;
    abs_c = c_neg ? X'(-cur_x100) : X'(cur_x100);
    abs_t = t_neg ? X'(-cmd.tgt100) : X'(cmd.tgt100);
    hit   = (cur_x100 >= cmd.win_lo) && (cur_x100 <= cmd.win_hi);

    // Accelerate only while the magnitude grows in the same direction
    opposite = (t_pos && c_neg) || (t_neg && c_pos);
    grow     = !opposite && (abs_t > abs_c);
    if (opposite) begin
      gap = {1'b0, abs_t} + {1'b0, abs_c};
    end else if (grow) begin
      gap = {1'b0, abs_t - abs_c};
    end else begin
      gap = {1'b0, abs_c - abs_t};
    end
    step  = grow ? steps.acc : steps.dec;
    // Clamp the step so the target is never overshot
    mag   = ({{(D-S){1'b0}}, step} < gap) ? step : gap[S-1:0];
    up    = grow ? t_pos : c_neg;
    moved = up ? cur_x100 + $signed({{(X-S){1'b0}}, mag})
               : cur_x100 - $signed({{(X-S){1'b0}}, mag});

    if (cmd.kind) begin
      cur_next = '0;
    end else if (hit) begin
      cur_next = cur_x100;
    end else begin
      cur_next = moved;
    end
  end

  always_comb begin
    old_q            = sisl_pkg::div100(exe_old);
    new_q            = sisl_pkg::div100(exe_new);
    res_next.speed   = sisl_pkg::SPD_W'(new_q);
    res_next.changed = new_q != old_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x100  <= '0;
      exe_valid <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      exe_valid <= cmd_take;
      if (cmd_take) cur_x100 <= cur_next;
      if (exe_valid) wr_ptr <= wr_ptr + 2'd1;
      if (deq) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, exe_valid} - {2'b0, deq};
    end
    if (cmd_take) begin
      exe_old <= cur_x100;
      exe_new <= cur_next;
    end
    if (exe_valid) begin
      mem[wr_ptr] <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(exe_valid && count == RES_DEPTH))
    else $error("back: result written into full queue");
  a_clear_speed: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.kind) |=> (cur_x100 == '0))
    else $error("back: clear item left speed nonzero");
  a_speed_bounded: assert property (@(posedge clk) disable iff (rst)
    (cur_x100 <= MAX_X100) && (cur_x100 >= -MAX_X100))
    else $error("back: scaled speed out of range");
  a_hold_on_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && !cmd.kind && hit) |=> $stable(cur_x100))
    else $error("back: speed moved although target was reached");
`endif

endmodule

FILE: test/sisl_speed_checker.sv
// Checker for the speed inertia slew limiter: watches the input, result and
// register write channels, predicts each result and compares it. Uses sisl_pkg.

module sisl_speed_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  sisl_pkg::in_t                   item,
  input  logic                            empty,
  input  logic                            pop,
  input  sisl_pkg::out_t                  result,
  input  logic                            cfg_wen,
  input  logic [sisl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sisl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);
  import sisl_pkg::*;

  longint acc_rate = 0;
  longint dec_rate = 0;
  longint tick_len = 100;
  longint spd_x100 = 0;   // current speed scaled by 100
  out_t   speed_due[$];   // predicted results, oldest first

  function automatic longint sgn(input longint v);
    return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Move the speed one tick toward the target and return the visible result
  function automatic out_t advance_speed(input in_t it);
    longint prev, aim, aim100, st, sc, step, room, inc, nxt;
    out_t   r;
    prev = spd_x100 / 100;
    aim  = longint'(it.target_speed);
    if (it.kind) begin
      spd_x100  = 0;
      r.speed   = '0;
      r.changed = (prev != 0);
      return r;
    end
    if (aim == prev) begin
      r.speed   = it.target_speed;
      r.changed = 1'b0;
      return r;
    end
    aim100 = aim * 100;
    st = sgn(aim);
    sc = sgn(spd_x100);
    if (st * sc >= 0) begin
      if (sc == 0) sc = st;
      if (mag(aim100) > mag(spd_x100)) begin
        step = (acc_rate * tick_len) / 10000;
        room = mag(aim100) - mag(spd_x100);
        inc  = sc * ((step < room) ? step : room);
      end else begin
        step = (dec_rate * tick_len) / 10000;
        room = mag(spd_x100) - mag(aim100);
        inc  = -sc * ((step < room) ? step : room);
      end
    end else begin
      // reversing: brake through zero toward the new direction
      step = (dec_rate * tick_len) / 10000;
      room = mag(aim100 - spd_x100);
      inc  = -sc * ((step < room) ? step : room);
    end
    spd_x100  = spd_x100 + inc;
    nxt       = spd_x100 / 100;
    r.speed   = SPD_W'(nxt);
    r.changed = (nxt != prev);
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      acc_rate = 0;
      dec_rate = 0;
      tick_len = 100;
      spd_x100 = 0;
      speed_due.delete();
      pending <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_ACCEL: acc_rate = longint'(cfg_wdata[RATE_W-1:0]);
          REG_DECEL: dec_rate = longint'(cfg_wdata[RATE_W-1:0]);
          REG_TICK:  tick_len = longint'(cfg_wdata[TICK_W-1:0]);
          default: ;
        endcase
      end
      if (push && !full) speed_due.push_back(advance_speed(item));
      if (pop && !empty) begin
        if (speed_due.size() == 0) begin
          $error("result transfer with no result expected: speed %0d changed %0b",
                 result.speed, result.changed);
          errors = errors + 1;
        end else begin
          want = speed_due.pop_front();
          if (result.speed !== want.speed) begin
            $error("speed: expected %0d, got %0d", want.speed, result.speed);
            errors = errors + 1;
          end
          if (result.changed !== want.changed) begin
            $error("changed: expected %0b, got %0b", want.changed, result.changed);
            errors = errors + 1;
          end
        end
      end
      pending <= speed_due.size();
    end
  end

endmodule

FILE: test/speed_inertia_slew_limiter_tb.sv
// Testbench top for the speed inertia slew limiter: clock, reset, stimulus and
// verdict. Depends on sisl_pkg, speed_inertia_slew_limiter and sisl_speed_checker.

module speed_inertia_slew_limiter_tb;
  import sisl_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  in_t                   item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_t                  result;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACCEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    errors;
  int                    pending;

  int sent = 0;      // input transfers so far
  bit quiet = 1'b0;  // no gaps and no stalls while set

  speed_inertia_slew_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sisl_speed_checker speed_check (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_t make_item(input logic kind, input logic signed [SPD_W-1:0] aim);
    in_t it;
    it.kind         = kind;
    it.target_speed = aim;
    return it;
  endfunction

  // Offer one item, with an occasional gap in front of it, and hold it until
  // the block takes it. push stays high between back-to-back transfers.
  task automatic offer(input in_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sent++;
  endtask

  // Let every result drain, give the pipeline time to go idle, then write
  // all three registers back to back.
  task automatic load_rates(input int unsigned acc, input int unsigned dec,
                            input int unsigned tick);
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_ACCEL;
    cfg_wdata <= CFG_DATA_W'(acc);
    @(posedge clk);
    cfg_index <= REG_DECEL;
    cfg_wdata <= CFG_DATA_W'(dec);
    @(posedge clk);
    cfg_index <= REG_TICK;
    cfg_wdata <= CFG_DATA_W'(tick);
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Result side: pop in random stall bursts, plus one long hold-off mid-run
  // so the result queue fills and full rises while items keep coming.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held && sent >= 500) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned acc, dec, tick;
    int run_left, pick;
    logic signed [SPD_W-1:0] aim;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset values: zero rates, so nothing may move
    offer(make_item(1'b0, 16'sd100));
    offer(make_item(1'b1, -16'sd32768));  // clear while already stopped
    offer(make_item(1'b0, 16'sd0));       // target already reached

    // Largest encodable accel rate and tick period: big steps, out-of-range values
    load_rates(16383, 10000, 131071);
    repeat (3) offer(make_item(1'b0, 16'sd32767));
    offer(make_item(1'b0, -16'sd32768));  // reverse while moving forward
    offer(make_item(1'b1, 16'sd32767));   // clear a moving speed
    offer(make_item(1'b1, 16'sd0));       // clear again, nothing changes
    repeat (2) offer(make_item(1'b0, -16'sd32768));
    offer(make_item(1'b0, 16'sd0));       // brake toward standstill
    offer(make_item(1'b0, 16'sd500));     // reverse from negative
    offer(make_item(1'b0, -16'sd1));

    // Step of one hundredth: scaled speed creeps without a visible change
    load_rates(10000, 10000, 1);
    repeat (3) offer(make_item(1'b0, 16'sd32767));
    offer(make_item(1'b0, -16'sd1));

    // Zero tick period: the step is zero whatever the rates
    load_rates(10000, 10000, 0);
    offer(make_item(1'b0, -16'sd32767));
    offer(make_item(1'b0, 16'sd1));

    // Random phases, each with its own rates; mostly held targets so the
    // speed ramps, brakes and reverses, with clears and noise mixed in.
    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 5))
        0:       acc = 0;
        1:       acc = 10000;
        2:       acc = 16383;
        default: acc = $urandom_range(1, 10000);
      endcase
      case ($urandom_range(0, 5))
        0:       dec = 0;
        1:       dec = 10000;
        2:       dec = 16383;
        default: dec = $urandom_range(1, 10000);
      endcase
      case ($urandom_range(0, 9))
        0:       tick = 0;
        1:       tick = 1;
        2:       tick = 131071;
        3:       tick = 100000;
        default: tick = $urandom_range(100, 100000);
      endcase
      load_rates(acc, dec, tick);
      quiet = (ph == 6 || ph == 10);
      run_left = 0;
      aim = '0;
      for (int k = 0; k < 150; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          offer(make_item(1'b1, SPD_W'($urandom)));
        end else if (pick < 12) begin
          offer(make_item(1'b0, SPD_W'($urandom)));
        end else begin
          if (run_left == 0) begin
            case ($urandom_range(0, 5))
              0: aim = SPD_W'($urandom_range(0, 600)) - 16'sd300;
              1: begin
                case ($urandom_range(0, 3))
                  0:       aim = 16'sd32767;
                  1:       aim = -16'sd32768;
                  2:       aim = -16'sd32767;
                  default: aim = 16'sd0;
                endcase
              end
              2: aim = SPD_W'($urandom_range(0, 4000)) - 16'sd2000;
              default: aim = SPD_W'($urandom);
            endcase
            run_left = $urandom_range(1, 24);
          end
          offer(make_item(1'b0, aim));
          run_left--;
        end
      end
    end

    // Drain: all results back, then a short wait for anything stray
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("speed_inertia_slew_limiter_tb: PASS");
    else
      $display("speed_inertia_slew_limiter_tb: FAIL");
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("speed_inertia_slew_limiter_tb: FAIL");
    $finish;
  end

endmodule
